// ===== design/chs_pkg.sv =====
package chs_pkg;

   localparam int unsigned CylWidth    = 10;
   localparam int unsigned SecWidth    = 6;
   localparam int unsigned HeadWidth   = 8;
   localparam int unsigned CcWidth     = 11;
   localparam int unsigned HcWidth     = 9;
   localparam int unsigned LbaWidth    = 32;
   localparam int unsigned IdxWidth    = CylWidth + HcWidth;
   localparam int unsigned ProdWidth   = IdxWidth + SecWidth;
   localparam int unsigned CsrIdxWidth = 3;
   localparam int unsigned CsrWidth    = 32;
   localparam int unsigned ReqWidth    = 32;
   localparam int unsigned RspWidth    = 72;

   typedef enum logic [1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_REPORT = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_BAD = 2'd1,
      ST_WP  = 2'd2
   } status_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_CYL_COUNT  = 3'd0,
      CSR_HEAD_COUNT = 3'd1,
      CSR_SPT        = 3'd2,
      CSR_IMAGE_BASE = 3'd3,
      CSR_WLOCK      = 3'd4,
      CSR_TYPE_CODE  = 3'd5,
      CSR_PRESENT    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0] max_head;
      logic [7:0] max_sector_cyl_high;
      logic [7:0] max_cyl_low;
      logic [7:0] report_type;
      logic       report_ok;
   } report_type_t_type;

   typedef struct packed {
      logic                 calc;
      status_type           status;
      logic [SecWidth-1:0]  sec_m1;
      report_type_t_type    report;
   } common_type;

endpackage

// ===== design/chs_to_lba_translator.sv =====
// Four-stage pipeline: decode and checks, cylinder times heads, times sectors, final add.
// The two multiplies and the base add set the stage split; beats pass every stage register.
// Throughput is one beat per cycle unless a low rsp_tready stalls the pipeline.
// Synchronous active-high reset empties the pipeline and loads the default geometry.
module chs_to_lba_translator
   import chs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // cmd, cyl_low, sector_and_cyl_high, head_sel
   input  logic [ReqWidth-1:0]    req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // lba, status_code, report_ok, report_type, max_cyl_low, max_sector_cyl_high, max_head
   output logic [RspWidth-1:0]    rsp_tdata,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_wdata
);

   logic [CcWidth-1:0]   cyl_count_ff;
   logic [HcWidth-1:0]   head_count_ff;
   logic [SecWidth-1:0]  spt_ff;
   logic [LbaWidth-1:0]  image_base_ff;
   logic                 wlock_ff;
   logic [7:0]           type_code_ff;
   logic                 present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cyl_count_ff  <= CcWidth'(1);
         head_count_ff <= HcWidth'(1);
         spt_ff        <= SecWidth'(1);
         image_base_ff <= '0;
         wlock_ff      <= 1'b0;
         type_code_ff  <= 8'd0;
         present_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CYL_COUNT:  cyl_count_ff  <= csr_wdata[CcWidth-1:0];
            CSR_HEAD_COUNT: head_count_ff <= csr_wdata[HcWidth-1:0];
            CSR_SPT:        spt_ff        <= csr_wdata[SecWidth-1:0];
            CSR_IMAGE_BASE: image_base_ff <= csr_wdata[LbaWidth-1:0];
            CSR_WLOCK:      wlock_ff      <= csr_wdata[0];
            CSR_TYPE_CODE:  type_code_ff  <= csr_wdata[7:0];
            CSR_PRESENT:    present_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic en1, en2, en3, en4;

   assign en4 = !v4_ff || rsp_tready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_tready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // Stage 1: field split, range checks, status and report.
   logic [1:0]           cmd;
   logic [7:0]           cyl_low;
   logic [7:0]           sch;
   logic [HeadWidth-1:0] head;
   logic [CylWidth-1:0]  cyl;
   logic [SecWidth-1:0]  sec;
   logic                 geom_ok;
   logic [CcWidth-1:0]   max_cyl;
   logic [HcWidth-1:0]   max_head;
   common_type           c1_in, c1_ff;
   logic [CylWidth-1:0]  cyl1_ff;
   logic [HeadWidth-1:0] head1_ff;

   assign cmd     = req_tdata[1:0];
   assign cyl_low = req_tdata[9:2];
   assign sch     = req_tdata[17:10];
   assign head    = req_tdata[25:18];
   assign cyl     = {sch[7:6], cyl_low};
   assign sec     = sch[SecWidth-1:0];
   assign max_cyl  = cyl_count_ff - CcWidth'(1);
   assign max_head = head_count_ff - HcWidth'(1);
   assign geom_ok = ({1'b0, cyl} < cyl_count_ff) && ({1'b0, head} < head_count_ff)
                    && (sec != '0) && (sec <= spt_ff);

   always_comb begin
      c1_in        = '0;
      c1_in.status = ST_OK;
      c1_in.sec_m1 = sec - SecWidth'(1);
      case (cmd) inside
         CMD_READ, CMD_WRITE: begin
            if (!present_ff || !geom_ok) begin
               c1_in.status = ST_BAD;
            end else if (cmd == CMD_WRITE && wlock_ff) begin
               c1_in.status = ST_WP;
            end else begin
               c1_in.calc = 1'b1;
            end
         end
         CMD_REPORT: begin
            if (present_ff) begin
               c1_in.report.report_ok           = 1'b1;
               c1_in.report.report_type         = type_code_ff;
               c1_in.report.max_cyl_low         = max_cyl[7:0];
               c1_in.report.max_sector_cyl_high = {max_cyl[9:8], spt_ff};
               c1_in.report.max_head            = max_head[7:0];
            end
         end
         default: c1_in.status = ST_BAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         c1_ff    <= c1_in;
         cyl1_ff  <= cyl;
         head1_ff <= head;
      end
   end

   // Stage 2: track index = cylinder * heads + head.
   common_type          c2_ff;
   logic [IdxWidth-1:0] idx_in, idx_ff;

   assign idx_in = (IdxWidth'(cyl1_ff) * IdxWidth'(head_count_ff)) + IdxWidth'(head1_ff);

   always_ff @(posedge clock) begin
      if (en2) begin
         c2_ff  <= c1_ff;
         idx_ff <= idx_in;
      end
   end

   // Stage 3: scale by sectors per track.
   common_type           c3_ff;
   logic [ProdWidth-1:0] prod_in, prod_ff;

   assign prod_in = ProdWidth'(idx_ff) * ProdWidth'(spt_ff);

   always_ff @(posedge clock) begin
      if (en3) begin
         c3_ff   <= c2_ff;
         prod_ff <= prod_in;
      end
   end

   // Stage 4: add image base and sector offset.
   logic [LbaWidth-1:0] lba_in, lba_ff;
   common_type          c4_ff;

   assign lba_in = c3_ff.calc
                   ? image_base_ff + LbaWidth'(prod_ff) + LbaWidth'(c3_ff.sec_m1)
                   : '0;

   always_ff @(posedge clock) begin
      if (en4) begin
         c4_ff  <= c3_ff;
         lba_ff <= lba_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {5'd0,
                        c4_ff.report.max_head,
                        c4_ff.report.max_sector_cyl_high,
                        c4_ff.report.max_cyl_low,
                        c4_ff.report.report_type,
                        c4_ff.report.report_ok,
                        c4_ff.status,
                        lba_ff};

endmodule

// ===== test/tb_chs_to_lba_translator.sv =====
`timescale 1ns / 100ps

module tb_chs_to_lba_translator
   import chs_pkg::*;
();

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int DrainCycles = 8;

   typedef struct packed {
      logic [7:0]  max_head;
      logic [7:0]  max_sector_cyl_high;
      logic [7:0]  max_cyl_low;
      logic [7:0]  report_type;
      logic        report_ok;
      status_type  status;
      logic [31:0] lba;
   } translation_type;

   typedef struct {
      logic [10:0] cyl_count;
      logic [8:0]  head_count;
      logic [5:0]  spt;
      logic [31:0] base;
      logic        wlock;
      logic [7:0]  type_code;
      logic        present;
   } geometry_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqWidth-1:0]    req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspWidth-1:0]    rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0]    csr_wdata = '0;

   geometry_type    drive_geo = '{cyl_count: 11'd1, head_count: 9'd1, spt: 6'd1, base: 32'd0,
                                  wlock: 1'b0, type_code: 8'd0, present: 1'b0};
   translation_type pending_results[$];
   int              send_gap_pct = 0;
   int              recv_stall_pct = 0;
   int              mismatches = 0;
   int              requests_sent = 0;
   int              results_checked = 0;
   int              geometries_loaded = 0;

   chs_to_lba_translator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic translation_type translate_request(logic [1:0] cmd, logic [7:0] cyl_low,
                                                          logic [7:0] sec_cyl_hi,
                                                          logic [7:0] head);
      translation_type r;
      logic [9:0]   cyl;
      logic [5:0]   sec;
      logic [10:0]  max_cyl;
      logic [8:0]   max_head;
      logic [31:0]  addr;
      logic         in_range;
      r = '0;
      cyl = {sec_cyl_hi[7:6], cyl_low};
      sec = sec_cyl_hi[5:0];
      in_range = drive_geo.present && ({1'b0, cyl} < drive_geo.cyl_count) &&
                 ({1'b0, head} < drive_geo.head_count) && (sec != 6'd0) &&
                 (sec <= drive_geo.spt);
      addr = drive_geo.base +
             (32'(cyl) * 32'(drive_geo.head_count) + 32'(head)) * 32'(drive_geo.spt) +
             32'(sec) - 32'd1;
      case (cmd) inside
         CMD_READ, CMD_WRITE: begin
            if (!in_range) begin
               r.status = ST_BAD;
            end else if (cmd == CMD_WRITE && drive_geo.wlock) begin
               r.status = ST_WP;
            end else begin
               r.lba = addr;
            end
         end
         CMD_REPORT: begin
            if (drive_geo.present) begin
               max_cyl = drive_geo.cyl_count - 11'd1;
               max_head = drive_geo.head_count - 9'd1;
               r.report_ok = 1'b1;
               r.report_type = drive_geo.type_code;
               r.max_cyl_low = max_cyl[7:0];
               r.max_sector_cyl_high = {max_cyl[9:8], drive_geo.spt};
               r.max_head = max_head[7:0];
            end
         end
         default: begin
            r.status = ST_BAD;
         end
      endcase
      return r;
   endfunction

   task automatic report_error(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(string field, logic [31:0] expected, logic [31:0] actual);
      if (expected !== actual) begin
         report_error($sformatf("%s expected 0x%0h, got 0x%0h", field, expected, actual));
      end
   endtask

   // Expectations are queued on the request beat and consumed on the response beat.
   always @(posedge clock) begin
      translation_type got;
      translation_type want;
      if (!reset && req_tvalid && req_tready) begin
         pending_results.push_back(translate_request(req_tdata[1:0], req_tdata[9:2],
                                                     req_tdata[17:10], req_tdata[25:18]));
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            report_error("response beat with no request outstanding");
         end else begin
            want = pending_results.pop_front();
            got = translation_type'(rsp_tdata[$bits(translation_type)-1:0]);
            check_field("lba", want.lba, got.lba);
            check_field("status_code", 32'(want.status), 32'(got.status));
            check_field("report_ok", 32'(want.report_ok), 32'(got.report_ok));
            check_field("report_type", 32'(want.report_type), 32'(got.report_type));
            check_field("max_cyl_low", 32'(want.max_cyl_low), 32'(got.max_cyl_low));
            check_field("max_sector_cyl_high", 32'(want.max_sector_cyl_high),
                        32'(got.max_sector_cyl_high));
            check_field("max_head", 32'(want.max_head), 32'(got.max_head));
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_request(logic [1:0] cmd, logic [7:0] cyl_low, logic [7:0] sec_cyl_hi,
                               logic [7:0] head);
      if ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_gap_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, head, sec_cyl_hi, cyl_low, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // Counting accepted request beats avoids racing the queue update on the last beat.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (results_checked < requests_sent) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic apply_geometry(geometry_type g);
      logic [CsrWidth-1:0] values[7];
      values[CSR_CYL_COUNT] = 32'(g.cyl_count);
      values[CSR_HEAD_COUNT] = 32'(g.head_count);
      values[CSR_SPT] = 32'(g.spt);
      values[CSR_IMAGE_BASE] = g.base;
      values[CSR_WLOCK] = 32'(g.wlock);
      values[CSR_TYPE_CODE] = 32'(g.type_code);
      values[CSR_PRESENT] = 32'(g.present);
      for (int i = 0; i < 7; i++) begin
         csr_we <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_wdata <= values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      drive_geo = g;
      geometries_loaded++;
   endtask

   function automatic int pick_below(int count, int cap);
      if (count <= 0) begin
         return $urandom_range(cap - 1);
      end
      return $urandom_range(((count < cap) ? count : cap) - 1);
   endfunction

   function automatic geometry_type random_geometry();
      geometry_type g;
      case ($urandom_range(9))
         0: g.cyl_count = 11'd1;
         1: g.cyl_count = 11'd1024;
         2: g.cyl_count = 11'($urandom_range(1025, 2047));
         3: g.cyl_count = 11'($urandom_range(1, 8));
         default: g.cyl_count = 11'($urandom_range(1, 1024));
      endcase
      case ($urandom_range(9))
         0: g.head_count = 9'd1;
         1: g.head_count = 9'd256;
         2: g.head_count = 9'($urandom_range(257, 511));
         3: g.head_count = 9'($urandom_range(1, 4));
         default: g.head_count = 9'($urandom_range(1, 256));
      endcase
      case ($urandom_range(5))
         0: g.spt = 6'd1;
         1: g.spt = 6'd63;
         default: g.spt = 6'($urandom_range(1, 63));
      endcase
      case ($urandom_range(5))
         0: g.base = 32'd0;
         1: g.base = 32'hffff_ffff;
         default: g.base = $urandom;
      endcase
      g.wlock = 1'($urandom_range(1));
      g.type_code = 8'($urandom_range(255));
      g.present = ($urandom_range(9) != 0);
      return g;
   endfunction

   // Most requests address a valid location of the current geometry; the rest are raw noise.
   task automatic send_random_request();
      int          pick;
      logic [1:0]  cmd;
      logic [9:0]  cyl;
      logic [5:0]  sec;
      logic [7:0]  head;
      pick = $urandom_range(99);
      if (pick < 45) begin
         cmd = CMD_READ;
      end else if (pick < 85) begin
         cmd = CMD_WRITE;
      end else if (pick < 97) begin
         cmd = CMD_REPORT;
      end else begin
         cmd = CMD_UNKNOWN;
      end
      if ($urandom_range(99) < 75) begin
         cyl = 10'(pick_below(drive_geo.cyl_count, 1024));
         head = 8'(pick_below(drive_geo.head_count, 256));
         sec = 6'(pick_below(drive_geo.spt, 63) + 1);
         send_request(cmd, cyl[7:0], {cyl[9:8], sec}, head);
      end else begin
         send_request(2'($urandom_range(3)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)));
      end
   endtask

   task automatic test_no_drive();
      send_request(CMD_READ, 8'd0, 8'd1, 8'd0);
      send_request(CMD_REPORT, 8'd0, 8'd0, 8'd0);
      send_request(CMD_UNKNOWN, 8'hff, 8'hff, 8'hff);
      wait_for_results();
   endtask

   task automatic test_address_extremes();
      apply_geometry('{cyl_count: 11'd1024, head_count: 9'd256, spt: 6'd63,
                       base: 32'hffff_ff00, wlock: 1'b0, type_code: 8'hab, present: 1'b1});
      send_request(CMD_READ, 8'd0, 8'd1, 8'd0);
      send_request(CMD_READ, 8'hff, 8'hff, 8'hff);
      send_request(CMD_WRITE, 8'hff, 8'hff, 8'hff);
      send_request(CMD_REPORT, 8'h00, 8'h00, 8'h00);
      send_request(CMD_UNKNOWN, 8'h12, 8'h05, 8'h03);
      wait_for_results();
   endtask

   task automatic test_geometry_limits();
      apply_geometry('{cyl_count: 11'd300, head_count: 9'd16, spt: 6'd17,
                       base: 32'h0000_1000, wlock: 1'b0, type_code: 8'h01, present: 1'b1});
      send_request(CMD_READ, 8'h2c, 8'h41, 8'd0);
      send_request(CMD_READ, 8'd0, 8'd1, 8'd16);
      send_request(CMD_READ, 8'd5, 8'd0, 8'd2);
      send_request(CMD_READ, 8'd5, 8'd18, 8'd2);
      send_request(CMD_READ, 8'h2b, 8'h51, 8'd15);
      wait_for_results();
   endtask

   task automatic test_write_protect();
      apply_geometry('{cyl_count: 11'd80, head_count: 9'd2, spt: 6'd18,
                       base: 32'h8000_0000, wlock: 1'b1, type_code: 8'h04, present: 1'b1});
      send_request(CMD_WRITE, 8'd10, 8'd9, 8'd1);
      send_request(CMD_WRITE, 8'd10, 8'd0, 8'd1);
      send_request(CMD_READ, 8'd10, 8'd9, 8'd1);
      send_request(CMD_REPORT, 8'd0, 8'd0, 8'd0);
      wait_for_results();
   endtask

   task automatic test_zero_geometry();
      apply_geometry('{cyl_count: 11'd0, head_count: 9'd0, spt: 6'd0,
                       base: 32'h0, wlock: 1'b0, type_code: 8'hff, present: 1'b1});
      send_request(CMD_READ, 8'd0, 8'd1, 8'd0);
      send_request(CMD_REPORT, 8'd0, 8'd0, 8'd0);
      wait_for_results();
   endtask

   task automatic test_random_traffic(int gap_pct, int stall_pct);
      send_gap_pct = gap_pct;
      recv_stall_pct = stall_pct;
      repeat (3) begin
         apply_geometry(random_geometry());
         repeat (45) send_random_request();
         wait_for_results();
      end
   endtask

   initial begin
      send_gap_pct = 33;
      recv_stall_pct = 88;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_drive();
      test_address_extremes();
      test_geometry_limits();
      test_write_protect();
      test_zero_geometry();
      test_random_traffic(33, 88);
      test_random_traffic(88, 33);
      test_random_traffic(0, 0);
      if (pending_results.size() != 0) begin
         report_error($sformatf("%0d responses never arrived", pending_results.size()));
      end
      $display("Sent %0d requests and checked %0d responses across %0d drive geometries.",
               requests_sent, results_checked, geometries_loaded);
      $display("Mismatches: %0d.", mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d responses outstanding.", pending_results.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
design/chs_pkg.sv
design/chs_to_lba_translator.sv
test/tb_chs_to_lba_translator.sv
